[sv/pwc_pkg.sv]
`timescale 1ns / 1ps

package pwc_pkg;

    // default coordinate width (signed 16.8 fixed point)
    localparam int COORD_BITS_DEF = 24;

    // clip stages: left, right, bottom, top
    localparam int NUM_STAGES = 4;
    localparam int STG_IDX_W  = 2;
    // stage tag of a work item: one more code for "leaves the last stage"
    localparam int STG_TAG_W  = 3;

    localparam int CNT_W      = 16;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MIN_Y = 2'd1;
    localparam logic [1:0] REG_MAX_X = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    // stage indexes
    localparam logic [STG_IDX_W-1:0] STG_LEFT   = 2'd0;
    localparam logic [STG_IDX_W-1:0] STG_RIGHT  = 2'd1;
    localparam logic [STG_IDX_W-1:0] STG_BOTTOM = 2'd2;
    localparam logic [STG_IDX_W-1:0] STG_TOP    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic                 load_in;
        logic                 sel_close;
        logic [STG_IDX_W-1:0] close_idx;
        logic                 upd_stage;
        logic                 start_cut;
        logic                 push_next;
        logic                 adv_cur;
        logic                 load_cut;
        logic                 pop;
        logic                 emit_vertex;
        logic                 emit_end;
        logic                 clear;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cur_out;
        logic has_first;
        logic in_a;
        logic in_b;
        logic stk_empty;
        logic out_free;
        logic cut_done;
    } t_dp_status;

endpackage

[sv/pwc_muldiv.sv]
`timescale 1ns / 1ps

// base + num * d / den, quotient truncated toward zero.
// Loads the operands, multiplies, then produces one quotient bit per cycle.
module pwc_muldiv
    import pwc_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_base,
    input  logic signed [W:0]   i_num,
    input  logic signed [W:0]   i_d,
    input  logic signed [W:0]   i_den,
    output logic                o_done,
    output logic [W-1:0]        o_res
);

    localparam int D  = W + 1;
    localparam int CW = $clog2(D + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]    r_phase;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [D-1:0]  r_a, r_b, r_den, r_rem, r_quo;
    logic          r_neg, r_zero;
    logic [W-1:0]  r_base;

    logic [D:0]    trial;
    logic          ge;

    // restoring division step
    assign trial = {r_rem, r_quo[D-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_phase <= PH_DIV;
                    r_cnt   <= '0;
                end
                PH_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(D - 1)) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_start) begin
            r_a    <= i_num[W] ? D'(-i_num) : D'(i_num);
            r_b    <= i_d[W] ? D'(-i_d) : D'(i_d);
            r_den  <= i_den[W] ? D'(-i_den) : D'(i_den);
            r_neg  <= i_num[W] ^ i_d[W] ^ i_den[W];
            r_zero <= (i_den == '0);
            r_base <= i_base;
        end else if (r_phase == PH_MUL) begin
            {r_rem, r_quo} <= r_a * r_b;
        end else if (r_phase == PH_DIV) begin
            r_rem <= ge ? D'(trial - {1'b0, r_den}) : trial[D-1:0];
            r_quo <= {r_quo[D-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_zero ? r_base
                  : (r_neg ? r_base - r_quo[W-1:0] : r_base + r_quo[W-1:0]);

endmodule

[sv/pwc_datapath.sv]
`timescale 1ns / 1ps

// Window registers, per-stage first/prev vertex, work stack, cut unit,
// output register and vertex counter.
module pwc_datapath
    import pwc_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_addr,
    input  logic [W-1:0]       i_cfg_wr_data,
    input  logic [W-1:0]       i_in_x,
    input  logic [W-1:0]       i_in_y,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [W-1:0]       o_out_x,
    output logic [W-1:0]       o_out_y,
    output logic               o_out_is_vertex,
    output logic               o_out_last,
    output logic [CNT_W-1:0]   o_out_count
);

    logic signed [W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;

    logic [W-1:0] r_first_x [NUM_STAGES];
    logic [W-1:0] r_first_y [NUM_STAGES];
    logic [W-1:0] r_prev_x  [NUM_STAGES];
    logic [W-1:0] r_prev_y  [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_has_first;

    logic [STG_TAG_W-1:0] r_cur_stg;
    logic [W-1:0]         r_cur_x, r_cur_y;

    logic [STG_TAG_W-1:0] r_stk_stg [NUM_STAGES];
    logic [W-1:0]         r_stk_x   [NUM_STAGES];
    logic [W-1:0]         r_stk_y   [NUM_STAGES];
    logic [STG_TAG_W-1:0] r_sp;

    logic [STG_IDX_W-1:0] r_cut_stg;
    logic [W-1:0]         r_cut_e;

    logic                 r_ov, r_oisv, r_olast;
    logic [W-1:0]         r_ox, r_oy;
    logic [CNT_W-1:0]     r_ocnt, r_cnt;

    logic [STG_IDX_W-1:0] idx, top;
    logic [W-1:0]         ax, ay, bx, by, edge_v, base;
    logic signed [W:0]    num, dd, den;
    logic                 axis_x, out_free, cut_done;
    logic [W-1:0]         cut_res;

    function automatic logic inside_f(input logic [STG_IDX_W-1:0] s,
                                      input logic signed [W-1:0] x,
                                      input logic signed [W-1:0] y,
                                      input logic signed [W-1:0] mnx,
                                      input logic signed [W-1:0] mxx,
                                      input logic signed [W-1:0] mny,
                                      input logic signed [W-1:0] mxy);
        logic r;
        unique case (s)
            STG_LEFT:   r = x >= mnx;
            STG_RIGHT:  r = x <= mxx;
            STG_BOTTOM: r = y >= mny;
            STG_TOP:    r = y <= mxy;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    // operand selection: normal step uses (cur, prev), closing uses (prev, first)
    assign idx = i_cmd.sel_close ? i_cmd.close_idx : r_cur_stg[STG_IDX_W-1:0];
    assign ax  = i_cmd.sel_close ? r_prev_x[idx]  : r_cur_x;
    assign ay  = i_cmd.sel_close ? r_prev_y[idx]  : r_cur_y;
    assign bx  = i_cmd.sel_close ? r_first_x[idx] : r_prev_x[idx];
    assign by  = i_cmd.sel_close ? r_first_y[idx] : r_prev_y[idx];
    assign top = STG_IDX_W'(r_sp - 1'b1);

    always_comb begin
        unique case (idx)
            STG_LEFT:   edge_v = r_min_x;
            STG_RIGHT:  edge_v = r_max_x;
            STG_BOTTOM: edge_v = r_min_y;
            STG_TOP:    edge_v = r_max_y;
            default:    edge_v = r_min_x;
        endcase
    end

    assign axis_x = (idx == STG_LEFT) || (idx == STG_RIGHT);

    // intersection operands, one bit wider than a coordinate
    always_comb begin
        if (axis_x) begin
            base = by;
            num  = $signed({edge_v[W-1], edge_v}) - $signed({bx[W-1], bx});
            dd   = $signed({ay[W-1], ay}) - $signed({by[W-1], by});
            den  = $signed({ax[W-1], ax}) - $signed({bx[W-1], bx});
        end else begin
            base = bx;
            num  = $signed({edge_v[W-1], edge_v}) - $signed({by[W-1], by});
            dd   = $signed({ax[W-1], ax}) - $signed({bx[W-1], bx});
            den  = $signed({ay[W-1], ay}) - $signed({by[W-1], by});
        end
    end

    pwc_muldiv #(.W(W)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_cut),
        .i_base  (base),
        .i_num   (num),
        .i_d     (dd),
        .i_den   (den),
        .o_done  (cut_done),
        .o_res   (cut_res)
    );

    assign out_free = !r_ov || i_out_ready;

    assign o_sts.cur_out   = (r_cur_stg == STG_TAG_W'(NUM_STAGES));
    assign o_sts.has_first = r_has_first[idx];
    assign o_sts.in_a      = inside_f(idx, ax, ay, r_min_x, r_max_x, r_min_y, r_max_y);
    assign o_sts.in_b      = inside_f(idx, bx, by, r_min_x, r_max_x, r_min_y, r_max_y);
    assign o_sts.stk_empty = (r_sp == '0);
    assign o_sts.out_free  = out_free;
    assign o_sts.cut_done  = cut_done;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_MIN_X: r_min_x <= i_cfg_wr_data;
                REG_MIN_Y: r_min_y <= i_cfg_wr_data;
                REG_MAX_X: r_max_x <= i_cfg_wr_data;
                REG_MAX_Y: r_max_y <= i_cfg_wr_data;
                default:   r_min_x <= r_min_x;
            endcase
        end
    end

    // control state: valid flags, stack pointer, output valid, counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_first <= '0;
            r_sp        <= '0;
            r_ov        <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.upd_stage) begin
                r_has_first[idx] <= 1'b1;
            end
            if (i_cmd.push_next) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.emit_vertex || i_cmd.emit_end) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.emit_vertex && r_cnt != '1) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.clear) begin
                r_has_first <= '0;
                r_cnt       <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_stage) begin
            if (!r_has_first[idx]) begin
                r_first_x[idx] <= r_cur_x;
                r_first_y[idx] <= r_cur_y;
            end
            r_prev_x[idx] <= r_cur_x;
            r_prev_y[idx] <= r_cur_y;
        end
        if (i_cmd.start_cut) begin
            r_cut_stg <= idx;
            r_cut_e   <= edge_v;
        end
        if (i_cmd.push_next) begin
            r_stk_stg[r_sp[STG_IDX_W-1:0]] <= r_cur_stg + 1'b1;
            r_stk_x[r_sp[STG_IDX_W-1:0]]   <= r_cur_x;
            r_stk_y[r_sp[STG_IDX_W-1:0]]   <= r_cur_y;
        end
        // current work item
        if (i_cmd.load_in) begin
            r_cur_stg <= '0;
            r_cur_x   <= i_in_x;
            r_cur_y   <= i_in_y;
        end else if (i_cmd.adv_cur) begin
            r_cur_stg <= r_cur_stg + 1'b1;
        end else if (i_cmd.load_cut) begin
            r_cur_stg <= STG_TAG_W'(r_cut_stg) + 1'b1;
            if ((r_cut_stg == STG_LEFT) || (r_cut_stg == STG_RIGHT)) begin
                r_cur_x <= r_cut_e;
                r_cur_y <= cut_res;
            end else begin
                r_cur_x <= cut_res;
                r_cur_y <= r_cut_e;
            end
        end else if (i_cmd.pop) begin
            r_cur_stg <= r_stk_stg[top];
            r_cur_x   <= r_stk_x[top];
            r_cur_y   <= r_stk_y[top];
        end
        // output register
        if (i_cmd.emit_vertex) begin
            r_ox    <= r_cur_x;
            r_oy    <= r_cur_y;
            r_oisv  <= 1'b1;
            r_olast <= 1'b0;
            r_ocnt  <= '0;
        end else if (i_cmd.emit_end) begin
            r_ox    <= '0;
            r_oy    <= '0;
            r_oisv  <= 1'b0;
            r_olast <= 1'b1;
            r_ocnt  <= r_cnt;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_x         = r_ox;
    assign o_out_y         = r_oy;
    assign o_out_is_vertex = r_oisv;
    assign o_out_last      = r_olast;
    assign o_out_count     = r_ocnt;

endmodule

[sv/pwc_ctrl.sv]
`timescale 1ns / 1ps

// Sequencer: walks one vertex depth first through the stages, then the
// closing pass on the last vertex, then the end marker.
module pwc_ctrl
    import pwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_last,
    output logic        o_in_ready,
    input  t_dp_status  i_sts,
    output t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_CLOSE = 3'd4;

    logic [2:0]           r_state, n_state;
    logic                 r_last, n_last;
    logic [STG_TAG_W-1:0] r_cs, n_cs;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_cs    = r_cs;
        o_cmd   = '0;
        o_cmd.close_idx = r_cs[STG_IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_last  = i_in_last;
                    n_cs    = '0;
                    n_state = S_EVAL;
                end
            end
            // one stage step for the current item, or hand it to the output
            S_EVAL: begin
                if (i_sts.cur_out) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_vertex = 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    o_cmd.upd_stage = 1'b1;
                    if (i_sts.has_first && (i_sts.in_a != i_sts.in_b)) begin
                        o_cmd.start_cut = 1'b1;
                        o_cmd.push_next = i_sts.in_a;
                        n_state = S_DIV;
                    end else if (i_sts.in_a) begin
                        o_cmd.adv_cur = 1'b1;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.cut_done) begin
                    o_cmd.load_cut = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_POP: begin
                if (!i_sts.stk_empty) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_EVAL;
                end else if (r_last) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // close each stage against its first vertex, then the end marker
            S_CLOSE: begin
                if (r_cs == STG_TAG_W'(NUM_STAGES)) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_end = 1'b1;
                        o_cmd.clear    = 1'b1;
                        n_last  = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.sel_close = 1'b1;
                    n_cs = r_cs + 1'b1;
                    if (i_sts.has_first && (i_sts.in_a != i_sts.in_b)) begin
                        o_cmd.start_cut = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_cs    <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_cs    <= n_cs;
        end
    end

endmodule

[sv/polygon_window_clipper_top.sv]
`timescale 1ns / 1ps
// Sutherland-Hodgman clipper, left/right/bottom/top, one vertex at a time.
// A boundary crossing loads the divider, multiplies, divides with one quotient bit per cycle
// and loads the result back before its intersection walks on.
// The next vertex is accepted only in idle; emitting a vertex waits for a free output.
// The last vertex adds the closing pass (4 steps plus its crossings) and the end marker.
// Synchronous active-low reset clears window registers, stage flags and count.
module polygon_window_clipper_top
    import pwc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_addr,
    input  logic [COORD_BITS-1:0] i_cfg_wr_data,
    // vertex input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // vertex_x, vertex_y
    input  logic                  s_axis_tlast,   // last_vertex
    // clipped output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // out_x, out_y, vertex_count
    output logic                  m_axis_tuser,   // is_vertex
    output logic                  m_axis_tlast    // last
);

    t_dp_cmd               cmd;
    t_dp_status            sts;
    logic [COORD_BITS-1:0] out_x, out_y;
    logic [CNT_W-1:0]      out_cnt;

    pwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pwc_datapath #(.W(COORD_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_x          (s_axis_tdata[COORD_BITS-1:0]),
        .i_in_y          (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_x         (out_x),
        .o_out_y         (out_y),
        .o_out_is_vertex (m_axis_tuser),
        .o_out_last      (m_axis_tlast),
        .o_out_count     (out_cnt)
    );

    assign m_axis_tdata = OUT_W'({out_cnt, out_y, out_x});

endmodule
